FILE: hdl/packed_2bpp_rect_fill_assert.svh
// Assertion macros for the checker file of the bitmap fill block.
`ifndef PACKED_2BPP_RECT_FILL_ASSERT_SVH
`define PACKED_2BPP_RECT_FILL_ASSERT_SVH

// Implication in the same cycle, switched off while reset is asserted.
`define P2RF_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("p2rf check failed");

// Implication into the next cycle, switched off while reset is asserted.
`define P2RF_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("p2rf check failed");

// Implication into the next cycle that also holds across reset.
`define P2RF_ASSERT_NXT_ALWAYS(name, ck, ante, cons) \
  name: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("p2rf check failed");

`endif

FILE: hdl/p2rf_pkg.sv
`default_nettype none

package p2rf_pkg;

  // Bitmap geometry.
  localparam int WIDTH         = 256;
  localparam int HEIGHT        = 256;
  localparam int PIX_PER_WORD  = 16;
  localparam int PIX_W         = 2;
  localparam int WORD_W        = PIX_PER_WORD * PIX_W;
  localparam int WORDS_PER_ROW = WIDTH / PIX_PER_WORD;
  localparam int USABLE_WIDTH  = WORDS_PER_ROW * PIX_PER_WORD;

  // Word store.
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Coordinate fields and derived widths.
  localparam int COORD_W   = 9;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int PIX_IDX_W = $clog2(PIX_PER_WORD);
  localparam int COL_W     = COORD_W - PIX_IDX_W;
  localparam int LIN_RAW_W = COORD_W + $clog2(WORDS_PER_ROW + 1) + 1;
  localparam int LIN_W     = (LIN_RAW_W > ADDR_W) ? LIN_RAW_W : ADDR_W + 1;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [PIX_IDX_W-1:0] pix_idx_t;
  typedef logic [PIX_IDX_W:0]   pix_cnt_t;

  // Saturation limits for x and y coordinates.
  localparam coord_t X_LIM = COORD_W'((USABLE_WIDTH > COORD_MAX) ? COORD_MAX : USABLE_WIDTH);
  localparam coord_t Y_LIM = COORD_W'((HEIGHT > COORD_MAX) ? COORD_MAX : HEIGHT);

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Clamp a coordinate to its limit.
  function automatic coord_t sat_coord(input coord_t v, input coord_t lim);
    return (v > lim) ? lim : v;
  endfunction

  // Bit mask that covers pixels lo up to hi-1 of one word.
  function automatic word_t edge_mask(input pix_idx_t lo, input pix_cnt_t hi);
    word_t    m;
    pix_cnt_t p_c;
    m = '0;
    for (int p = 0; p < PIX_PER_WORD; p++) begin
      p_c = (PIX_IDX_W + 1)'(p);
      if ((p_c >= {1'b0, lo}) && (p_c < hi)) begin
        m[PIX_W*p +: PIX_W] = '1;
      end
    end
    return m;
  endfunction

  // Repeat a color over every pixel slot of a word.
  function automatic word_t spread_color(input logic [PIX_W-1:0] c);
    return {PIX_PER_WORD{c}};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/p2rf_ram.sv
`default_nettype none

// Single-port synchronous RAM with a registered read.
module p2rf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One address per cycle: an optional write, and a registered read of the word held there before it.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

FILE: hdl/packed_2bpp_rect_fill.sv
// Results: a word write, an unused opcode or an empty fill strobes its result in the cycle
// after the transfer; a word read strobes once S_RD_WAIT has captured the store data.
// A fill walks the covered words row by row; a full word is written directly, while each
// partial edge word costs a read first, as the single store port does one access per cycle.
// Reset: a pass clears all 4096 store words, with busy high; the receiver cannot stall.
`default_nettype none

module packed_2bpp_rect_fill (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic [p2rf_pkg::COORD_W-1:0]      in_x_left,
  input  wire logic [p2rf_pkg::COORD_W-1:0]      in_y_top,
  input  wire logic [p2rf_pkg::COORD_W-1:0]      in_x_right,
  input  wire logic [p2rf_pkg::COORD_W-1:0]      in_y_bottom,
  input  wire logic [1:0]                        in_color,
  input  wire logic [p2rf_pkg::ADDR_W-1:0]       in_word_address,
  input  wire logic [p2rf_pkg::WORD_W-1:0]       in_write_data,
  output logic                                   out_valid,
  output logic [p2rf_pkg::WORD_W-1:0]            out_read_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_MERGE,
    S_RD_WAIT
  } state_t;

  state_t                              state_r;
  logic [p2rf_pkg::ADDR_W-1:0]         clr_r;
  logic [p2rf_pkg::COL_W-1:0]          first_r;
  logic [p2rf_pkg::COL_W-1:0]          last_r;
  logic [p2rf_pkg::COL_W-1:0]          wi_r;
  p2rf_pkg::pix_idx_t                  lo_r;
  p2rf_pkg::pix_cnt_t                  hi_r;
  p2rf_pkg::coord_t                    y_r;
  p2rf_pkg::coord_t                    y_end_r;
  p2rf_pkg::word_t                     pattern_r;
  logic                                out_valid_r;
  p2rf_pkg::word_t                     out_data_r;

  logic                                accept;
  p2rf_pkg::coord_t                    xl_sat;
  p2rf_pkg::coord_t                    xr_sat;
  p2rf_pkg::coord_t                    yt_sat;
  p2rf_pkg::coord_t                    yb_sat;
  p2rf_pkg::coord_t                    xr_m1;
  logic                                fill_empty;
  p2rf_pkg::pix_idx_t                  cur_lo;
  p2rf_pkg::pix_cnt_t                  cur_hi;
  p2rf_pkg::word_t                     mask;
  logic                                mask_full;
  logic [p2rf_pkg::LIN_W-1:0]          lin_addr;
  logic                                in_range;
  logic                                row_done;
  p2rf_pkg::coord_t                    y_inc;
  logic                                fill_done;
  logic                                ram_we;
  logic [p2rf_pkg::ADDR_W-1:0]         ram_addr;
  p2rf_pkg::word_t                     ram_wdata;
  p2rf_pkg::word_t                     ram_rdata;

  assign accept        = start && (state_r == S_IDLE);
  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // Clamp the rectangle and decide whether it covers anything.
  assign xl_sat     = p2rf_pkg::sat_coord(in_x_left, p2rf_pkg::X_LIM);
  assign xr_sat     = p2rf_pkg::sat_coord(in_x_right, p2rf_pkg::X_LIM);
  assign yt_sat     = p2rf_pkg::sat_coord(in_y_top, p2rf_pkg::Y_LIM);
  assign yb_sat     = p2rf_pkg::sat_coord(in_y_bottom, p2rf_pkg::Y_LIM);
  assign xr_m1      = xr_sat - p2rf_pkg::coord_t'(1);
  assign fill_empty = (xl_sat >= xr_sat) || (yt_sat >= yb_sat);

  // Pixel mask and store address of the current fill word.
  assign cur_lo    = (wi_r == first_r) ? lo_r : '0;
  assign cur_hi    = (wi_r == last_r) ? hi_r
                                      : (p2rf_pkg::PIX_IDX_W + 1)'(p2rf_pkg::PIX_PER_WORD);
  assign mask      = p2rf_pkg::edge_mask(cur_lo, cur_hi);
  assign mask_full = &mask;
  assign lin_addr  = p2rf_pkg::LIN_W'(y_r) * p2rf_pkg::LIN_W'(p2rf_pkg::WORDS_PER_ROW)
                   + p2rf_pkg::LIN_W'(wi_r);
  assign in_range  = lin_addr < p2rf_pkg::LIN_W'(p2rf_pkg::STORE_DEPTH);

  // Walk position: end of row and end of rectangle.
  assign row_done  = (wi_r == last_r);
  assign y_inc     = y_r + p2rf_pkg::coord_t'(1);
  assign fill_done = row_done && (y_inc == y_end_r);

  // Store port: clearing, single word access, or fill read and write back.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = lin_addr[p2rf_pkg::ADDR_W-1:0];
    ram_wdata = pattern_r;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_addr  = in_word_address;
        ram_wdata = in_write_data;
        ram_we    = accept && (p2rf_pkg::opcode_t'(in_opcode) == p2rf_pkg::OP_WRITE);
      end
      S_FILL: begin
        ram_we = in_range && mask_full;
      end
      S_MERGE: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata & ~mask) | (pattern_r & mask);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + p2rf_pkg::ADDR_W'(1);
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            out_data_r <= '0;
            case (p2rf_pkg::opcode_t'(in_opcode))
              p2rf_pkg::OP_FILL: begin
                first_r   <= xl_sat[p2rf_pkg::COORD_W-1:p2rf_pkg::PIX_IDX_W];
                wi_r      <= xl_sat[p2rf_pkg::COORD_W-1:p2rf_pkg::PIX_IDX_W];
                last_r    <= xr_m1[p2rf_pkg::COORD_W-1:p2rf_pkg::PIX_IDX_W];
                lo_r      <= xl_sat[p2rf_pkg::PIX_IDX_W-1:0];
                hi_r      <= {1'b0, xr_m1[p2rf_pkg::PIX_IDX_W-1:0]}
                           + p2rf_pkg::pix_cnt_t'(1);
                y_r       <= yt_sat;
                y_end_r   <= yb_sat;
                pattern_r <= p2rf_pkg::spread_color(in_color);
                if (fill_empty) begin
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_FILL;
                end
              end
              p2rf_pkg::OP_READ: begin
                state_r <= S_RD_WAIT;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_FILL, S_MERGE: begin
          if ((state_r == S_FILL) && in_range && !mask_full) begin
            // Partial edge word: its old value arrives next cycle for the merge.
            state_r <= S_MERGE;
          end else if (fill_done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_FILL;
            if (row_done) begin
              wi_r <= first_r;
              y_r  <= y_inc;
            end else begin
              wi_r <= wi_r + p2rf_pkg::COL_W'(1);
            end
          end
        end
        S_RD_WAIT: begin
          out_data_r  <= ram_rdata;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  p2rf_ram #(
    .WIDTH (p2rf_pkg::WORD_W),
    .DEPTH (p2rf_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: hdl/p2rf_checker.sv
`default_nettype none

`include "packed_2bpp_rect_fill_assert.svh"

// Port-level checks of the bitmap fill block.
module p2rf_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic [1:0]                     in_opcode,
  input wire logic                           out_valid,
  input wire logic [p2rf_pkg::WORD_W-1:0]    out_read_data
);

  logic acc;
  logic acc_read;
  logic acc_fill;
  logic acc_quick;

  assign acc       = start && !busy;
  assign acc_read  = acc && (in_opcode == p2rf_pkg::OP_READ);
  assign acc_fill  = acc && (in_opcode == p2rf_pkg::OP_FILL);
  assign acc_quick = acc && ((in_opcode == p2rf_pkg::OP_WRITE) ||
                             (in_opcode == p2rf_pkg::OP_NONE));

  // Reset starts the clearing pass, which keeps the block busy.
  `P2RF_ASSERT_NXT_ALWAYS(a_reset_busy, clk, !rst_n, busy)

  // A word write or an unused opcode gives a zero result in the next cycle.
  `P2RF_ASSERT_NXT(a_quick_result, clk, rst_n, acc_quick, out_valid && (out_read_data == '0))

  // A word read keeps the block busy, with no result, while it waits for the registered store read.
  `P2RF_ASSERT_NXT(a_read_timing, clk, rst_n, acc_read, busy && !out_valid)

  // A fill either finishes at once (empty) or keeps the block busy.
  `P2RF_ASSERT_NXT(a_fill_progress, clk, rst_n, acc_fill, out_valid || busy)

endmodule

bind packed_2bpp_rect_fill p2rf_checker u_p2rf_checker (.*);

`default_nettype wire
